### design/summed_area_table_engine_defines.svh
// assertion macros for the summed area table engine
// expects clk and rst_n in the scope of every use
`ifndef SUMMED_AREA_TABLE_ENGINE_DEFINES_SVH
`define SUMMED_AREA_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication, off during reset
`define SAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sat_pkg.sv
// shared types, constants and helpers of the summed area table engine
// no dependencies
package sat_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int DIM_W     = 7;
    localparam int PIX_W     = 16;
    localparam int SUM_W     = 32;
    localparam int CFG_IDX_W = 4;
    localparam int S_TDATA_W = 48;
    localparam int NSLOT     = 4;
    localparam int SLOT_W    = 2;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NSLOT - 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // input word payload, last field in the lowest bits
    typedef struct packed {
        logic [6:0]       rect_h;
        logic [6:0]       rect_w;
        logic [5:0]       rect_y;
        logic [5:0]       rect_x;
        logic [PIX_W-1:0] pixel;
    } sat_item_t;

    localparam int ITEM_W = $bits(sat_item_t);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } sat_state_t;

    typedef struct packed {
        logic              latch;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_slot;
        logic              acc_en;
        logic [SLOT_W-1:0] acc_slot;
        logic              write_en;
        logic              out_load;
    } sat_cmd_t;

    typedef struct packed {
        logic is_query;
    } sat_status_t;

    // zero reads as one, anything above the maximum as the maximum
    function automatic logic [DIM_W-1:0] sat_clamp(input logic [DIM_W-1:0] v, input int maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > maxv)
            r = DIM_W'(maxv);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] sat_addr(input logic [COL_W-1:0] x,
                                                   input logic [ROW_W-1:0] y);
        return ADDR_W'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

endpackage

### design/sat_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/sat_ctrl.sv
// controller: sequences the four table reads, the write back and the output slot
// depends on sat_pkg
module sat_ctrl import sat_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  sat_status_t status,
    output sat_cmd_t    cmd
);

    sat_state_t        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    slot_next  = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_slot = slot_reg;
                // data of the previous slot lands this cycle
                if (slot_reg != '0)
                begin
                    cmd.acc_en   = 1'b1;
                    cmd.acc_slot = slot_reg - SLOT_W'(1);
                end
                slot_next = slot_reg + SLOT_W'(1);
                if (slot_reg == SLOT_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.acc_en   = 1'b1;
                cmd.acc_slot = SLOT_LAST;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.is_query)
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.write_en = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

### design/sat_datapath.sv
// datapath: config registers, write position, corner addresses, table ram, accumulator
// depends on sat_pkg and sat_ram
module sat_datapath import sat_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  sat_item_t            item,
    input  logic                 func,
    input  sat_cmd_t             cmd,
    output sat_status_t          status,
    output logic [SUM_W-1:0]     rect_sum,
    output logic                 query_error
);

    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              loaded_reg, loaded_next;

    logic              is_query_reg;
    logic              bad_reg;
    logic [ADDR_W-1:0] addr_reg [NSLOT];
    logic [NSLOT-1:0]  en_reg;
    logic [NSLOT-1:0]  sub_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              err_reg;

    logic [ADDR_W-1:0] addr_next [NSLOT];
    logic [NSLOT-1:0]  en_next;
    logic [NSLOT-1:0]  sub_next;
    logic              bad_next;
    logic [7:0]        x_end, y_end;
    logic [COL_W-1:0]  qx_right, qx_left, lx_left;
    logic [ROW_W-1:0]  qy_bottom, qy_top, ly_top;
    logic [SUM_W-1:0]  rdata;
    logic [SUM_W-1:0]  term;

    // corner positions for both kinds of item
    always_comb
    begin
        x_end     = 8'(item.rect_x) + 8'(item.rect_w);
        y_end     = 8'(item.rect_y) + 8'(item.rect_h);
        qx_right  = COL_W'(x_end - 8'd1);
        qy_bottom = ROW_W'(y_end - 8'd1);
        qx_left   = COL_W'(8'(item.rect_x) - 8'd1);
        qy_top    = ROW_W'(8'(item.rect_y) - 8'd1);
        lx_left   = col_reg - COL_W'(1);
        ly_top    = row_reg - ROW_W'(1);
        bad_next  = !loaded_reg || (item.rect_w == '0) || (item.rect_h == '0) ||
                    (x_end > 8'(width_reg)) || (y_end > 8'(height_reg));
    end

    // per-slot address, enable and sign
    always_comb
    begin
        if (func == FUNC_QUERY)
        begin
            addr_next[0] = sat_addr(qx_right, qy_bottom);
            addr_next[1] = sat_addr(qx_right, qy_top);
            addr_next[2] = sat_addr(qx_left, qy_bottom);
            addr_next[3] = sat_addr(qx_left, qy_top);
            en_next[0]   = !bad_next;
            en_next[1]   = !bad_next && (item.rect_y != '0);
            en_next[2]   = !bad_next && (item.rect_x != '0);
            en_next[3]   = !bad_next && (item.rect_x != '0) && (item.rect_y != '0);
            sub_next     = 4'b0110;
        end
        else
        begin
            addr_next[0] = sat_addr(col_reg, ly_top);
            addr_next[1] = sat_addr(lx_left, row_reg);
            addr_next[2] = sat_addr(lx_left, ly_top);
            addr_next[3] = sat_addr(col_reg, row_reg);
            en_next[0]   = (row_reg != '0);
            en_next[1]   = (col_reg != '0);
            en_next[2]   = (col_reg != '0) && (row_reg != '0);
            en_next[3]   = 1'b0;
            sub_next     = 4'b0100;
        end
    end

    sat_ram #(
        .WIDTH(SUM_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (cmd.write_en),
        .waddr(sat_addr(col_reg, row_reg)),
        .wdata(acc_reg),
        .re   (cmd.rd_en),
        .raddr(addr_reg[cmd.rd_slot]),
        .rdata(rdata)
    );

    assign term = en_reg[cmd.acc_slot] ? rdata : '0;

    // config writes and raster position
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        loaded_next = loaded_reg;
        if (cfg_valid && ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT)))
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
                width_next = sat_clamp(cfg_data, MAX_WIDTH);
            else
                height_next = sat_clamp(cfg_data, MAX_HEIGHT);
            col_next    = '0;
            row_next    = '0;
            loaded_next = 1'b0;
        end
        else if (cmd.write_en)
        begin
            if (int'(col_reg) + 1 >= int'(width_reg))
            begin
                col_next = '0;
                if (int'(row_reg) + 1 >= int'(height_reg))
                begin
                    row_next    = '0;
                    loaded_next = 1'b1;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sat_clamp(DIM_W'(64), MAX_WIDTH);
            height_reg <= sat_clamp(DIM_W'(64), MAX_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            loaded_reg <= loaded_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            is_query_reg <= func;
            bad_reg      <= bad_next && (func == FUNC_QUERY);
            addr_reg     <= addr_next;
            en_reg       <= en_next;
            sub_reg      <= sub_next;
            acc_reg      <= (func == FUNC_QUERY) ? '0 : SUM_W'(item.pixel);
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= sub_reg[cmd.acc_slot] ? (acc_reg - term) : (acc_reg + term);
        end
        if (cmd.out_load)
        begin
            sum_reg <= bad_reg ? '0 : acc_reg;
            err_reg <= bad_reg;
        end
    end

    assign status.is_query = is_query_reg;
    assign rect_sum        = sum_reg;
    assign query_error     = err_reg;

endmodule

### design/summed_area_table_engine.sv
// summed area table engine: load a frame of 16-bit pixels, then query rectangle sums
// channels: s_* input words, m_* result words, cfg_* register writes
// tuser on the input is func (0 load, 1 query); tuser on the output is query_error
// each word steps through IDLE to take it, READ for four reads through the single read port of
// the table ram, DRAIN for the last read data, FINISH to write back or load the output register
// a query result shows on m_tvalid once FINISH has loaded the output register
// loads give no result word; they build the table in raster order
// the output register is separate, so the next word is taken while a result waits
// if the receiver stalls, a second query holds in its last step until the slot frees
// reset: image_width = image_height = 64, write position 0,0, no frame loaded;
// the table itself is not cleared, every entry is written before any query reads it
// cfg writes are taken every cycle; any write to a known register restarts the frame
// queries before a full frame, of zero size or running outside the frame give
// query_error = 1 with rect_sum = 0
`include "summed_area_table_engine_defines.svh"

module summed_area_table_engine import sat_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    // input word
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pixel[15:0], rect_x, rect_y, rect_w, rect_h, unused pad
    input  logic                 s_tuser,   // func
    // result word
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SUM_W-1:0]     m_tdata,   // rect_sum
    output logic                 m_tuser,   // query_error
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    sat_cmd_t    cmd;
    sat_status_t status;
    sat_item_t   item;

    // upper pad bits of the input word carry nothing
    assign item      = sat_item_t'(s_tdata[ITEM_W-1:0]);
    assign cfg_ready = 1'b1;

    sat_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .status  (status),
        .cmd     (cmd)
    );

    sat_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item       (item),
        .func       (s_tuser),
        .cmd        (cmd),
        .status     (status),
        .rect_sum   (m_tdata),
        .query_error(m_tuser)
    );

    // the engine works one word at a time
    `SAT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    // a new result never overwrites one still waiting
    `SAT_ASSERT_NOW(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready, "result overwritten")
    // rejected queries report a zero sum
    `SAT_ASSERT_NOW(a_error_zero, m_tvalid && m_tuser, m_tdata == '0, "error with nonzero sum")

endmodule
